@@ hw/rtl/etok_pkg.sv @@
// etok_pkg: shared types and constants for the expression tokenizer.
// It holds the request and response structs, the token kind and error codes,
// and the push bundle that passes from the lexer to the response queue.
package etok_pkg;

   localparam int POS_WIDTH   = 32;
   localparam int VALUE_WIDTH = 63;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_WIDTH  = $clog2(QUEUE_DEPTH);
   localparam int QCNT_WIDTH  = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic {
      CMD_BYTE = 1'b0,
      CMD_END  = 1'b1
   } command_type;

   typedef enum logic [4:0] {
      KIND_EOF    = 5'd0,
      KIND_BAD    = 5'd1,
      KIND_SPACE  = 5'd2,
      KIND_NUMBER = 5'd3,
      KIND_IDENT  = 5'd4,
      KIND_PLUS   = 5'd5,
      KIND_MINUS  = 5'd6,
      KIND_STAR   = 5'd7,
      KIND_SLASH  = 5'd8,
      KIND_LPAREN = 5'd9,
      KIND_RPAREN = 5'd10,
      KIND_BANG   = 5'd11,
      KIND_BANGEQ = 5'd12,
      KIND_ANDAND = 5'd13,
      KIND_OROR   = 5'd14,
      KIND_EQ     = 5'd15,
      KIND_EQEQ   = 5'd16
   } kind_type;

   typedef enum logic [1:0] {
      ERR_NONE     = 2'd0,
      ERR_BAD_CHAR = 2'd1,
      ERR_OVERFLOW = 2'd2
   } error_type;

   typedef struct packed {
      logic       command;
      logic [7:0] char_byte;
   } req_type;

   typedef struct packed {
      logic [4:0]             token_kind;
      logic [31:0]            start_position;
      logic [31:0]            token_length;
      logic [VALUE_WIDTH-1:0] number_value;
      logic [1:0]             error_code;
      logic [7:0]             offending_byte;
      logic                   run_last;
   } rsp_type;

   // Up to two tokens leave the lexer for one request; count says how many.
   typedef struct packed {
      logic [1:0] count;
      rsp_type    tok0;
      rsp_type    tok1;
   } push_type;

endpackage

@@ hw/rtl/etok_lexer.sv @@
// etok_lexer: the tokenizer state and the single-pass logic that lexes one
// request byte or end command into zero, one or two tokens.
// Depends on etok_pkg for the request, response and push types.
module etok_lexer import etok_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     fire,
   input  req_type  req,
   output push_type push
);

   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_NINE   = 8'h39;
   localparam logic [7:0] CH_LOW_A  = 8'h61;
   localparam logic [7:0] CH_LOW_Z  = 8'h7A;
   localparam logic [7:0] CH_UP_A   = 8'h41;
   localparam logic [7:0] CH_UP_Z   = 8'h5A;
   localparam logic [7:0] CH_UNDER  = 8'h5F;
   localparam logic [7:0] CH_BANG   = 8'h21;
   localparam logic [7:0] CH_EQUAL  = 8'h3D;
   localparam logic [7:0] CH_AMP    = 8'h26;
   localparam logic [7:0] CH_PIPE   = 8'h7C;
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;

   localparam int SUM_WIDTH = VALUE_WIDTH + 4;

   typedef enum logic [7:0] {
      MODE_IDLE   = 8'b0000_0001,
      MODE_SPACE  = 8'b0000_0010,
      MODE_NUMBER = 8'b0000_0100,
      MODE_IDENT  = 8'b0000_1000,
      MODE_BANG   = 8'b0001_0000,
      MODE_EQ     = 8'b0010_0000,
      MODE_AMP    = 8'b0100_0000,
      MODE_PIPE   = 8'b1000_0000
   } mode_type;

   mode_type               mode_ff, mode_in;
   logic [POS_WIDTH-1:0]   start_ff, start_in;
   logic [POS_WIDTH-1:0]   pos_ff, pos_in;
   logic [VALUE_WIDTH-1:0] acc_ff, acc_in;
   logic                   ovf_ff, ovf_in;
   logic                   ended_ff, ended_in;

   logic [7:0]             b;
   logic                   b_space, b_digit, b_letter;
   logic [POS_WIDTH-1:0]   run_len;
   logic [SUM_WIDTH-1:0]   acc_wide, acc_sum;
   logic                   flush_v, first_v, second_v;
   rsp_type                flush_tok, first_tok, second_tok;
   logic [1:0]             count;

   function automatic rsp_type make_tok(kind_type kind, logic [POS_WIDTH-1:0] start,
                                        logic [POS_WIDTH-1:0] len,
                                        logic [VALUE_WIDTH-1:0] value,
                                        error_type err, logic [7:0] byte_val);
      rsp_type t;
      t.token_kind     = kind;
      t.start_position = start[31:0];
      t.token_length   = len[31:0];
      t.number_value   = value;
      t.error_code     = err;
      t.offending_byte = byte_val;
      t.run_last       = 1'b0;
      return t;
   endfunction

   localparam logic [POS_WIDTH-1:0]   LEN_ONE = POS_WIDTH'(1);
   localparam logic [POS_WIDTH-1:0]   LEN_TWO = POS_WIDTH'(2);
   localparam logic [VALUE_WIDTH-1:0] VAL_ZERO = '0;

   assign b        = req.char_byte;
   assign b_space  = (b == CH_SPACE) || (b == CH_TAB) || (b == CH_LF) || (b == CH_CR);
   assign b_digit  = (b >= CH_ZERO) && (b <= CH_NINE);
   assign b_letter = ((b >= CH_LOW_A) && (b <= CH_LOW_Z)) ||
                     ((b >= CH_UP_A) && (b <= CH_UP_Z)) || (b == CH_UNDER);
   assign run_len  = pos_ff - start_ff;

   // Ten times the accumulator plus the digit, built from two shifts.
   assign acc_wide = {4'b0000, acc_ff};
   assign acc_sum  = (acc_wide << 3) + (acc_wide << 1) + {{(SUM_WIDTH-4){1'b0}}, b[3:0]};

   // Token for whatever is pending, ending just before the current position.
   always_comb begin
      flush_v   = 1'b1;
      flush_tok = make_tok(KIND_EOF, start_ff, run_len, VAL_ZERO, ERR_NONE, 8'h00);
      case (mode_ff)
         MODE_SPACE: begin
            flush_tok = make_tok(KIND_SPACE, start_ff, run_len, VAL_ZERO, ERR_NONE, 8'h00);
         end
         MODE_NUMBER: begin
            if (ovf_ff) begin
               flush_tok = make_tok(KIND_NUMBER, start_ff, run_len, VAL_ZERO,
                                    ERR_OVERFLOW, 8'h00);
            end else begin
               flush_tok = make_tok(KIND_NUMBER, start_ff, run_len, acc_ff,
                                    ERR_NONE, 8'h00);
            end
         end
         MODE_IDENT: begin
            flush_tok = make_tok(KIND_IDENT, start_ff, run_len, VAL_ZERO, ERR_NONE, 8'h00);
         end
         MODE_BANG: begin
            flush_tok = make_tok(KIND_BANG, start_ff, LEN_ONE, VAL_ZERO, ERR_NONE, 8'h00);
         end
         MODE_EQ: begin
            flush_tok = make_tok(KIND_EQ, start_ff, LEN_ONE, VAL_ZERO, ERR_NONE, 8'h00);
         end
         MODE_AMP: begin
            flush_tok = make_tok(KIND_BAD, start_ff, LEN_ONE, VAL_ZERO, ERR_BAD_CHAR, CH_AMP);
         end
         MODE_PIPE: begin
            flush_tok = make_tok(KIND_BAD, start_ff, LEN_ONE, VAL_ZERO, ERR_BAD_CHAR, CH_PIPE);
         end
         default: begin
            flush_v = 1'b0;
         end
      endcase
   end

   // Main lexing step. The first slot carries a flushed or paired token, the
   // second one a token that the current byte finishes by itself.
   always_comb begin
      logic done;
      done       = 1'b0;
      mode_in    = mode_ff;
      start_in   = start_ff;
      pos_in     = pos_ff;
      acc_in     = acc_ff;
      ovf_in     = ovf_ff;
      ended_in   = ended_ff;
      first_v    = 1'b0;
      first_tok  = flush_tok;
      second_v   = 1'b0;
      second_tok = make_tok(KIND_EOF, pos_ff, '0, VAL_ZERO, ERR_NONE, 8'h00);

      if (req.command == CMD_END) begin
         first_v  = flush_v;
         second_v = 1'b1;
         mode_in  = MODE_IDLE;
         ended_in = 1'b1;
      end else if (!ended_ff) begin
         case (mode_ff)
            MODE_SPACE: begin
               done = b_space;
            end
            MODE_NUMBER: begin
               if (b_digit) begin
                  done = 1'b1;
                  if (!ovf_ff) begin
                     if (acc_sum[SUM_WIDTH-1:VALUE_WIDTH] != '0) begin
                        ovf_in = 1'b1;
                        acc_in = '0;
                     end else begin
                        acc_in = acc_sum[VALUE_WIDTH-1:0];
                     end
                  end
               end
            end
            MODE_IDENT: begin
               done = b_letter || b_digit;
            end
            MODE_BANG: begin
               if (b == CH_EQUAL) begin
                  done      = 1'b1;
                  first_v   = 1'b1;
                  first_tok = make_tok(KIND_BANGEQ, start_ff, LEN_TWO, VAL_ZERO,
                                       ERR_NONE, 8'h00);
               end
            end
            MODE_EQ: begin
               if (b == CH_EQUAL) begin
                  done      = 1'b1;
                  first_v   = 1'b1;
                  first_tok = make_tok(KIND_EQEQ, start_ff, LEN_TWO, VAL_ZERO,
                                       ERR_NONE, 8'h00);
               end
            end
            MODE_AMP: begin
               if (b == CH_AMP) begin
                  done      = 1'b1;
                  first_v   = 1'b1;
                  first_tok = make_tok(KIND_ANDAND, start_ff, LEN_TWO, VAL_ZERO,
                                       ERR_NONE, 8'h00);
               end
            end
            MODE_PIPE: begin
               if (b == CH_PIPE) begin
                  done      = 1'b1;
                  first_v   = 1'b1;
                  first_tok = make_tok(KIND_OROR, start_ff, LEN_TWO, VAL_ZERO,
                                       ERR_NONE, 8'h00);
               end
            end
            default: begin
               done = 1'b0;
            end
         endcase

         if (first_v) begin
            mode_in = MODE_IDLE;
         end

         if (!done) begin
            // Close what was pending, then lex this byte fresh.
            first_v  = flush_v;
            start_in = pos_ff;
            mode_in  = MODE_IDLE;
            if (b_space) begin
               mode_in = MODE_SPACE;
            end else if (b_digit) begin
               mode_in = MODE_NUMBER;
               acc_in  = {{(VALUE_WIDTH-4){1'b0}}, b[3:0]};
               ovf_in  = 1'b0;
            end else if (b_letter) begin
               mode_in = MODE_IDENT;
            end else if (b == CH_BANG) begin
               mode_in = MODE_BANG;
            end else if (b == CH_EQUAL) begin
               mode_in = MODE_EQ;
            end else if (b == CH_AMP) begin
               mode_in = MODE_AMP;
            end else if (b == CH_PIPE) begin
               mode_in = MODE_PIPE;
            end else begin
               second_v = 1'b1;
               case (b)
                  CH_PLUS:   second_tok = make_tok(KIND_PLUS, pos_ff, LEN_ONE, VAL_ZERO,
                                                   ERR_NONE, 8'h00);
                  CH_MINUS:  second_tok = make_tok(KIND_MINUS, pos_ff, LEN_ONE, VAL_ZERO,
                                                   ERR_NONE, 8'h00);
                  CH_STAR:   second_tok = make_tok(KIND_STAR, pos_ff, LEN_ONE, VAL_ZERO,
                                                   ERR_NONE, 8'h00);
                  CH_SLASH:  second_tok = make_tok(KIND_SLASH, pos_ff, LEN_ONE, VAL_ZERO,
                                                   ERR_NONE, 8'h00);
                  CH_LPAREN: second_tok = make_tok(KIND_LPAREN, pos_ff, LEN_ONE, VAL_ZERO,
                                                   ERR_NONE, 8'h00);
                  CH_RPAREN: second_tok = make_tok(KIND_RPAREN, pos_ff, LEN_ONE, VAL_ZERO,
                                                   ERR_NONE, 8'h00);
                  default:   second_tok = make_tok(KIND_BAD, pos_ff, LEN_ONE, VAL_ZERO,
                                                   ERR_BAD_CHAR, b);
               endcase
            end
         end
         pos_in = pos_ff + LEN_ONE;
      end
   end

   // Pack the tokens to the front and mark the last one of the request.
   always_comb begin
      count     = {1'b0, first_v} + {1'b0, second_v};
      push.tok1 = second_tok;
      if (first_v) begin
         push.tok0 = first_tok;
      end else begin
         push.tok0 = second_tok;
      end
      if (count == 2'd2) begin
         push.tok1.run_last = 1'b1;
      end else begin
         push.tok0.run_last = 1'b1;
      end
      push.count = fire ? count : 2'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         start_ff <= '0;
         pos_ff   <= '0;
         acc_ff   <= '0;
         ovf_ff   <= 1'b0;
         ended_ff <= 1'b0;
      end else if (fire) begin
         mode_ff  <= mode_in;
         start_ff <= start_in;
         pos_ff   <= pos_in;
         acc_ff   <= acc_in;
         ovf_ff   <= ovf_in;
         ended_ff <= ended_in;
      end
   end

endmodule

@@ hw/rtl/etok_queue.sv @@
// etok_queue: small response queue that takes up to two tokens a cycle from
// the lexer and hands out one a cycle unless stalled. Depends on etok_pkg.
module etok_queue import etok_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  push_type push,
   output logic     room,
   output logic     rsp_valid,
   input  logic     rsp_stall,
   output rsp_type  rsp_data
);

   rsp_type                entry_ff [QUEUE_DEPTH];
   logic [QPTR_WIDTH-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_WIDTH-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_WIDTH-1:0]  count_ff, count_in;
   logic                   pop;
   logic [QPTR_WIDTH-1:0]  wr_next;

   // Room for a full pair of tokens, judged before this cycle's pop.
   assign room      = count_ff <= QCNT_WIDTH'(QUEUE_DEPTH - 2);
   assign rsp_valid = count_ff != '0;
   assign rsp_data  = entry_ff[rd_ptr_ff];
   assign pop       = rsp_valid && !rsp_stall;
   assign wr_next   = wr_ptr_ff + QPTR_WIDTH'(1);

   always_comb begin
      wr_ptr_in = wr_ptr_ff + QPTR_WIDTH'(push.count);
      rd_ptr_in = rd_ptr_ff + QPTR_WIDTH'(pop);
      count_in  = count_ff + QCNT_WIDTH'(push.count) - QCNT_WIDTH'(pop);
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push.tok0;
      end
      if (push.count == 2'd2) begin
         entry_ff[wr_next] <= push.tok1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

@@ hw/rtl/expression_tokenizer.sv @@
// expression_tokenizer: top level of the streaming tokenizer.
// Instantiates etok_lexer and etok_queue and uses the types of etok_pkg.

// The tokenizer takes source text as a stream of requests, one byte each,
// closed by an end command, and returns tokens on the response channel:
// whitespace runs, decimal numbers with their value, identifiers, the single
// operators + - * / ( ), and the pairs ! or !=, = or ==, && and ||. A lone
// ampersand, a lone pipe or any other byte becomes a one-byte bad token that
// carries the byte. A multi-byte token is held until a byte arrives that
// cannot extend it, so one request returns zero, one or two tokens; run_last
// marks the last token of each request. The end command flushes what is
// pending and then returns an end token; bytes after it are dropped. A
// request is taken into an input register, lexed against the token state,
// and its tokens are written into a four-entry response queue. The block
// accepts one request per clock while the queue has room for two more tokens;
// the response side drains one token per clock while not stalled, so a steady
// stream of requests that each yield one token runs at one request per clock,
// and the response rate alone bounds a text that yields more tokens.
module expression_tokenizer import etok_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic     req_valid_ff, req_valid_in;
   req_type  req_data_ff;
   logic     room;
   logic     fire;
   push_type push;

   // The held request is lexed as soon as the queue can take both of its
   // possible tokens. The stall toward the sender depends on registers only.
   assign fire         = req_valid_ff && room;
   assign req_stall    = req_valid_ff && !room;
   assign req_valid_in = req_stall ? req_valid_ff : req_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
      end
   end

   // The payload register needs no reset; it loads on every accepted request.
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         req_data_ff <= req_data;
      end
   end

   etok_lexer u_lexer (
      .clock (clock),
      .reset (reset),
      .fire  (fire),
      .req   (req_data_ff),
      .push  (push)
   );

   etok_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
